// ===== sv/suid_pkg.sv =====
package suid_pkg;

  // Width of one stored id.
  localparam int unsigned IdW = 32;

  // Width of the slot and count result fields.
  localparam int unsigned OutW = 9;

  // Default number of entries in the store.
  localparam int unsigned CapacityDef = 256;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

endpackage

// ===== sv/suid_mem.sv =====
module suid_mem import suid_pkg::*; #(
  parameter int unsigned Depth = CapacityDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [IdW-1:0]   wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [IdW-1:0]   rdata_o
);

  logic [IdW-1:0] mem_q [Depth];
  logic [IdW-1:0] rdata_q;

  // One write port; entries are undefined until written.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // One read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sorted_unique_id_insert.sv =====
// The search is a binary search over the stored ids; each probe passes through the
// states S_PROBE and S_NARROW on the single memory read port. It is followed by
// the shift, which moves one entry per cycle through that port.
// The block takes a new id only once the last one is done; busy is low again in the strobe cycle.
// The receiver cannot stall; done_o is high for exactly one cycle per id.
// Reset (rst_ni low, asynchronous) empties the store and returns to idle.
module sorted_unique_id_insert import suid_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [IdW-1:0] new_id_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic [OutW-1:0]       slot_o,
  output logic [OutW-1:0]       count_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PROBE  = 6'b000010,
    S_NARROW = 6'b000100,
    S_CHECK  = 6'b001000,
    S_SHIFT  = 6'b010000,
    S_PLACE  = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic signed [IdW-1:0] id_q, id_d;
  logic [CntW-1:0]       lo_q, lo_d;
  logic [CntW-1:0]       hi_q, hi_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [CntW-1:0]       j_q, j_d;
  logic                  pend_q, pend_d;
  logic [AddrW-1:0]      pend_addr_q, pend_addr_d;
  logic                  done_q, done_d;
  status_e               status_q, status_d;
  logic [OutW-1:0]       slot_q, slot_d;
  logic [OutW-1:0]       count_q, count_d;
  logic [CntW-1:0]       mid;
  logic [CntW-1:0]       j_dec;
  logic                  full;
  logic                  miss;
  logic                  mem_we;
  logic [AddrW-1:0]      mem_waddr;
  logic [IdW-1:0]        mem_wdata;
  logic                  mem_re;
  logic [AddrW-1:0]      mem_raddr;
  logic [IdW-1:0]        mem_rdata;

  suid_mem #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Shared search arithmetic: midpoint of the open range, the shift index step and fullness.
  assign mid   = lo_q + ((hi_q - lo_q) >> 1);
  assign j_dec = j_q - CntW'(1);
  assign full  = (cnt_q == CntW'(CAPACITY));

  // Sequencer for search, duplicate check, shift and placement.
  always_comb begin
    state_d     = state_q;
    id_d        = id_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    cnt_d       = cnt_q;
    j_d         = j_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    done_d      = 1'b0;
    status_d    = status_q;
    slot_d      = slot_q;
    count_d     = count_q;
    miss        = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = pend_addr_q;
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = mid[AddrW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          id_d    = new_id_i;
          lo_d    = '0;
          hi_d    = cnt_q;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (lo_q < hi_q) begin
          mem_re  = 1'b1;
          state_d = S_NARROW;
        end else if (lo_q < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = lo_q[AddrW-1:0];
          state_d   = S_CHECK;
        end else begin
          miss = 1'b1;
        end
      end
      S_NARROW: begin
        if ($signed(mem_rdata) < id_q) begin
          lo_d = mid + CntW'(1);
        end else begin
          hi_d = mid;
        end
        state_d = S_PROBE;
      end
      S_CHECK: begin
        if ($signed(mem_rdata) == id_q) begin
          done_d   = 1'b1;
          status_d = ST_PRESENT;
          slot_d   = OutW'(lo_q);
          count_d  = OutW'(cnt_q);
          state_d  = S_IDLE;
        end else begin
          miss = 1'b1;
        end
      end
      S_SHIFT: begin
        // Write the entry read last cycle one place up, and read the next one.
        mem_we = pend_q;
        if (j_q > lo_q) begin
          mem_re      = 1'b1;
          mem_raddr   = j_dec[AddrW-1:0];
          pend_d      = 1'b1;
          pend_addr_d = j_q[AddrW-1:0];
          j_d         = j_dec;
        end else begin
          pend_d  = 1'b0;
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = lo_q[AddrW-1:0];
        mem_wdata = id_q;
        cnt_d     = cnt_q + CntW'(1);
        done_d    = 1'b1;
        status_d  = ST_INSERTED;
        slot_d    = OutW'(lo_q);
        count_d   = OutW'(cnt_q + CntW'(1));
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Id not present: drop it when full, otherwise open a gap at the found slot.
    if (miss) begin
      if (full) begin
        done_d   = 1'b1;
        status_d = ST_FULL;
        slot_d   = OutW'(cnt_q);
        count_d  = OutW'(cnt_q);
        state_d  = S_IDLE;
      end else begin
        j_d     = cnt_q;
        pend_d  = 1'b0;
        state_d = S_SHIFT;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk_i) begin
    id_q        <= id_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    j_q         <= j_d;
    pend_addr_q <= pend_addr_d;
    status_q    <= status_d;
    slot_q      <= slot_d;
    count_q     <= count_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign slot_o   = slot_q;
  assign count_o  = count_q;

  // The store never holds more than its capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  // A transfer always starts a search.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("accepted id did not start work");

  // A result appears only as the block returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");

  // An inserted id lands below the new count, which grew by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (done_o && status_o == ST_INSERTED) |-> (slot_o < count_o && cnt_q != $past(cnt_q)))
    else $error("insert result inconsistent with count");

endmodule
